// ----- rtl/mfsp_pkg.sv -----
// Package for the MIDI file stream parser: phase encoding, role, error and warning codes.
// Used by mfsp_core and midi_file_stream_parser_top; depends on nothing else.
`default_nettype none
package mfsp_pkg;
   localparam int VLQ_MAX_BYTES = 4;

   typedef enum logic [4:0] {
      PH_HDR_TAG, PH_HDR_LEN, PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV, PH_HDR_SKIP,
      PH_TRK_TAG, PH_TRK_LEN, PH_DELTA, PH_STATUS, PH_CHAN_DATA, PH_SYX_LEN,
      PH_SYX_DATA, PH_META_TYPE, PH_META_LEN, PH_META_DATA, PH_TRK_SKIP,
      PH_DONE, PH_STOP
   } phase_type;

   localparam logic [3:0] ROLE_HEADER    = 4'd0;
   localparam logic [3:0] ROLE_DELTA     = 4'd1;
   localparam logic [3:0] ROLE_STATUS    = 4'd2;
   localparam logic [3:0] ROLE_CHAN      = 4'd3;
   localparam logic [3:0] ROLE_SYX_LEN   = 4'd4;
   localparam logic [3:0] ROLE_SYX_DATA  = 4'd5;
   localparam logic [3:0] ROLE_META_TYPE = 4'd6;
   localparam logic [3:0] ROLE_META_LEN  = 4'd7;
   localparam logic [3:0] ROLE_META_TEXT = 4'd8;
   localparam logic [3:0] ROLE_META_OTH  = 4'd9;
   localparam logic [3:0] ROLE_SKIP      = 4'd10;
   localparam logic [3:0] ROLE_CHUNK_LEN = 4'd11;
   localparam logic [3:0] ROLE_IDLE      = 4'd12;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_MTHD  = 3'd1;
   localparam logic [2:0] ERR_HDR_SHORT = 3'd2;
   localparam logic [2:0] ERR_FORMAT   = 3'd3;
   localparam logic [2:0] ERR_NO_MTRK  = 3'd4;
   localparam logic [2:0] ERR_NO_RS    = 3'd5;
   localparam logic [2:0] ERR_VLQ_LONG = 3'd6;

   localparam logic [1:0] WARN_NONE     = 2'd0;
   localparam logic [1:0] WARN_SYS_COM  = 2'd1;
   localparam logic [1:0] WARN_REALTIME = 2'd2;

   localparam logic [7:0] META_EOT   = 8'h2F;
   localparam logic [7:0] STAT_SYSEX = 8'hF0;
   localparam logic [7:0] STAT_META  = 8'hFF;

   typedef struct packed {
      logic [3:0]  role;
      logic [15:0] track_index;
      logic [7:0]  meta_type;
      logic        text_last;
      logic [7:0]  status_byte;
      logic [2:0]  error_code;
      logic [1:0]  warning;
      logic        length_mismatch;
      logic [31:0] length_difference;
      logic        done_res;
   } result_type;

   function automatic logic [7:0] tag_letter(input logic head, input logic [1:0] i);
      logic [7:0] c;
      case (i)
         2'd0: c = 8'h4D;
         2'd1: c = 8'h54;
         2'd2: c = head ? 8'h68 : 8'h72;
         default: c = head ? 8'h64 : 8'h6B;
      endcase
      return c;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/mfsp_core.sv -----
// Parser state and per-byte decode: one byte in, one combinational result out.
// Depends on mfsp_pkg.
`default_nettype none
module mfsp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               new_file,
   output mfsp_pkg::result_type    result
);
   import mfsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] field_ff, field_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] cend_ff, cend_in;
   logic [31:0] hlen_ff, hlen_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] ntrk_ff, ntrk_in;
   logic [15:0] trk_ff, trk_in;
   logic [8:0]  rs_ff, rs_in;
   logic [27:0] acc_ff, acc_in;
   logic [2:0]  qcnt_ff, qcnt_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [2:0]  err_ff, err_in;

   // Values after an optional restart by new_file.
   phase_type   ph;
   logic [31:0] fc, ps, ce, hl;
   logic [15:0] ff, nt, ct;
   logic [8:0]  rs;
   logic [27:0] ac;
   logic [2:0]  qc, le;
   logic [7:0]  mt;

   logic [27:0] vbase;
   logic [27:0] vacc;
   logic [2:0]  vcnt;
   logic [1:0]  vres;
   logic [31:0] fdec;
   logic [32:0] diff_wide;
   logic [31:0] diff_sat;
   logic [16:0] target;
   logic [15:0] trk_next;
   logic        text_m, ended, fin_hdr, fin_trk;
   logic [7:0]  b;

   always_comb begin
      b = data_byte;
      if (new_file) begin
         ph = PH_HDR_TAG; fc = '0; ps = '0; ce = '0; hl = '0; ff = '0; nt = '0;
         ct = '0; rs = '0; ac = '0; qc = '0; mt = '0; le = ERR_NONE;
      end else begin
         ph = phase_ff; fc = field_ff; ps = pos_ff; ce = cend_ff; hl = hlen_ff;
         ff = fmt_ff; nt = ntrk_ff; ct = trk_ff; rs = rs_ff; ac = acc_ff;
         qc = qcnt_ff; mt = mtype_ff; le = err_ff;
      end
      if (ph >= PH_DELTA && ph <= PH_TRK_SKIP && ps != 32'hFFFF_FFFF) begin
         ps = ps + 32'd1;
      end
   end

   // Variable-length quantity step and shared helpers.
   always_comb begin
      vbase = (qc == 3'd0) ? 28'd0 : ac;
      vacc = {vbase[20:0], b[6:0]};
      vcnt = qc + 3'd1;
      if (b[7]) begin
         vres = (vcnt >= 3'(VLQ_MAX_BYTES)) ? 2'd2 : 2'd0;
      end else begin
         vres = 2'd1;
      end
      fdec = (fc != 32'd0) ? fc - 32'd1 : fc;
      diff_wide = {1'b0, ps} - {1'b0, ce};
      // Both operands are unsigned 32-bit, so the signed difference fits 33 bits.
      if (!diff_wide[32] && diff_wide[31]) begin
         diff_sat = 32'h7FFF_FFFF;
      end else if (diff_wide[32] && !diff_wide[31]) begin
         diff_sat = 32'h8000_0000;
      end else begin
         diff_sat = diff_wide[31:0];
      end
      target = (ff == 16'd0) ? 17'd1 : {1'b0, nt};
      trk_next = (ct != 16'hFFFF) ? ct + 16'd1 : ct;
      text_m = (mt >= 8'd1) && (mt <= 8'd15);
   end

   always_comb begin
      phase_in = ph; field_in = fc; pos_in = ps; cend_in = ce; hlen_in = hl;
      fmt_in = ff; ntrk_in = nt; trk_in = ct; rs_in = rs; acc_in = ac;
      qcnt_in = qc; mtype_in = mt; err_in = le;
      result = '0;
      result.role = ROLE_IDLE;
      ended = 1'b0;
      fin_hdr = 1'b0;
      fin_trk = 1'b0;
      case (ph)
         PH_HDR_TAG, PH_TRK_TAG: begin
            result.role = ROLE_HEADER;
            if (b != tag_letter(ph == PH_HDR_TAG, fc[1:0])) begin
               err_in = (ph == PH_HDR_TAG) ? ERR_NO_MTHD : ERR_NO_MTRK;
               phase_in = PH_STOP;
            end else if (fc[1:0] == 2'd3) begin
               field_in = '0;
               phase_in = (ph == PH_HDR_TAG) ? PH_HDR_LEN : PH_TRK_LEN;
            end else begin
               field_in = {30'd0, fc[1:0]} + 32'd1;
            end
         end
         PH_HDR_LEN: begin
            result.role = ROLE_HEADER;
            hlen_in = {hl[23:0], b};
            field_in = fc + 32'd1;
            if (field_in >= 32'd4) begin
               field_in = '0;
               if (hlen_in < 32'd6) begin
                  err_in = ERR_HDR_SHORT;
                  phase_in = PH_STOP;
               end else begin
                  phase_in = PH_HDR_FMT;
               end
            end
         end
         PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV: begin
            result.role = ROLE_HEADER;
            if (ph == PH_HDR_FMT) fmt_in = {ff[7:0], b};
            if (ph == PH_HDR_NTRK) ntrk_in = {nt[7:0], b};
            field_in = fc + 32'd1;
            if (field_in >= 32'd2) begin
               field_in = '0;
               if (ph == PH_HDR_FMT) begin
                  phase_in = PH_HDR_NTRK;
               end else if (ph == PH_HDR_NTRK) begin
                  phase_in = PH_HDR_DIV;
               end else if (hl > 32'd6) begin
                  field_in = hl - 32'd6;
                  phase_in = PH_HDR_SKIP;
               end else begin
                  fin_hdr = 1'b1;
               end
            end
         end
         PH_HDR_SKIP: begin
            result.role = ROLE_SKIP;
            field_in = fdec;
            if (fdec == 32'd0) fin_hdr = 1'b1;
         end
         PH_TRK_LEN: begin
            result.role = ROLE_CHUNK_LEN;
            cend_in = {ce[23:0], b};
            field_in = fc + 32'd1;
            if (field_in >= 32'd4) begin
               field_in = '0;
               pos_in = '0;
               rs_in = '0;
               qcnt_in = '0;
               phase_in = PH_DELTA;
            end
         end
         PH_DELTA: begin
            result.role = ROLE_DELTA;
            acc_in = vacc;
            qcnt_in = (vres == 2'd1) ? 3'd0 : vcnt;
            if (vres == 2'd2) begin
               err_in = ERR_VLQ_LONG;
               phase_in = PH_STOP;
            end else if (vres == 2'd1) begin
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!b[7]) begin
               result.role = ROLE_CHAN;
               if (!rs[8]) begin
                  err_in = ERR_NO_RS;
                  phase_in = PH_STOP;
               end else begin
                  result.status_byte = rs[7:0];
                  if (rs[7:4] == 4'hC || rs[7:4] == 4'hD) begin
                     phase_in = PH_DELTA;
                  end else begin
                     field_in = 32'd1;
                     phase_in = PH_CHAN_DATA;
                  end
               end
            end else if (b < 8'hF0) begin
               result.role = ROLE_STATUS;
               result.status_byte = b;
               rs_in = {1'b1, b};
               field_in = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 32'd1 : 32'd2;
               phase_in = PH_CHAN_DATA;
            end else begin
               result.role = ROLE_STATUS;
               result.status_byte = b;
               if (b == STAT_SYSEX) begin
                  phase_in = PH_SYX_LEN;
               end else if (b == STAT_META) begin
                  phase_in = PH_META_TYPE;
               end else begin
                  result.warning = (b <= 8'hF6) ? WARN_SYS_COM : WARN_REALTIME;
                  phase_in = PH_DELTA;
               end
            end
         end
         PH_CHAN_DATA: begin
            result.role = ROLE_CHAN;
            result.status_byte = rs[7:0];
            field_in = fdec;
            if (fdec == 32'd0) phase_in = PH_DELTA;
         end
         PH_SYX_LEN: begin
            result.role = ROLE_SYX_LEN;
            result.status_byte = STAT_SYSEX;
            acc_in = vacc;
            qcnt_in = (vres == 2'd1) ? 3'd0 : vcnt;
            if (vres == 2'd2) begin
               err_in = ERR_VLQ_LONG;
               phase_in = PH_STOP;
            end else if (vres == 2'd1) begin
               field_in = {4'd0, vacc};
               phase_in = (vacc == 28'd0) ? PH_DELTA : PH_SYX_DATA;
            end
         end
         PH_SYX_DATA: begin
            result.role = ROLE_SYX_DATA;
            result.status_byte = STAT_SYSEX;
            field_in = fdec;
            if (fdec == 32'd0) phase_in = PH_DELTA;
         end
         PH_META_TYPE: begin
            result.role = ROLE_META_TYPE;
            result.status_byte = STAT_META;
            mtype_in = b;
            result.meta_type = b;
            phase_in = PH_META_LEN;
         end
         PH_META_LEN: begin
            result.role = ROLE_META_LEN;
            result.status_byte = STAT_META;
            result.meta_type = mt;
            acc_in = vacc;
            qcnt_in = (vres == 2'd1) ? 3'd0 : vcnt;
            if (vres == 2'd2) begin
               err_in = ERR_VLQ_LONG;
               phase_in = PH_STOP;
            end else if (vres == 2'd1) begin
               field_in = {4'd0, vacc};
               if (vacc == 28'd0) ended = 1'b1;
               else phase_in = PH_META_DATA;
            end
         end
         PH_META_DATA: begin
            result.role = text_m ? ROLE_META_TEXT : ROLE_META_OTH;
            result.status_byte = STAT_META;
            result.meta_type = mt;
            field_in = fdec;
            if (fdec == 32'd0) begin
               ended = 1'b1;
               result.text_last = text_m;
            end
         end
         PH_TRK_SKIP: begin
            result.role = ROLE_SKIP;
            field_in = fdec;
            if (fdec == 32'd0) fin_trk = 1'b1;
         end
         default: begin
            result.role = ROLE_IDLE;
         end
      endcase

      if (ended) begin
         if (mt == META_EOT) begin
            result.length_mismatch = (ps != ce);
            result.length_difference = diff_sat;
            if (ce > ps) begin
               field_in = ce - ps;
               phase_in = PH_TRK_SKIP;
            end else begin
               fin_trk = 1'b1;
            end
         end else begin
            phase_in = PH_DELTA;
         end
      end

      if (fin_hdr) begin
         if (ff > 16'd1) begin
            err_in = ERR_FORMAT;
            phase_in = PH_STOP;
         end else begin
            trk_in = '0;
            if (target == 17'd0) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_TRK_TAG;
               field_in = '0;
            end
         end
      end
      if (fin_trk) begin
         trk_in = trk_next;
         if ({1'b0, trk_next} >= target) begin
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_TRK_TAG;
            field_in = '0;
         end
      end

      result.track_index = trk_in;
      result.error_code = err_in;
      result.done_res = (phase_in == PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR_TAG;
         field_ff <= '0; pos_ff <= '0; cend_ff <= '0; hlen_ff <= '0;
         fmt_ff <= '0; ntrk_ff <= '0; trk_ff <= '0; rs_ff <= '0;
         acc_ff <= '0; qcnt_ff <= '0; mtype_ff <= '0; err_ff <= ERR_NONE;
      end else if (step) begin
         phase_ff <= phase_in;
         field_ff <= field_in; pos_ff <= pos_in; cend_ff <= cend_in; hlen_ff <= hlen_in;
         fmt_ff <= fmt_in; ntrk_ff <= ntrk_in; trk_ff <= trk_in; rs_ff <= rs_in;
         acc_ff <= acc_in; qcnt_ff <= qcnt_in; mtype_ff <= mtype_in; err_ff <= err_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/midi_file_stream_parser_top.sv -----
// Top level of the MIDI file stream parser: input register, parser core, result register.
// Depends on mfsp_pkg and mfsp_core.
// Usage:
//   The req_ channel carries one file byte per transaction, with req_new_file set on the
//   first byte of a file. The rsp_ channel returns exactly one result per byte: its role
//   in the file, the track number, meta and status information, warnings, the latched
//   error and the done flag.
//   A byte accepted is held in the input register and decoded combinationally by the
//   parser core; its result is registered in the output register when the output
//   register is empty or rsp_ready is high, and rsp_valid is raised with it.
//   Throughput is one byte per cycle while the receiver does not stall; the parser state
//   update for a byte is combinational logic between the input and output registers.
//   When the receiver stalls, the result stays in the output register and the input
//   register keeps one more byte; req_ready falls only when both are full and
//   rsp_ready is low.
//   Reset clears the valid flags and puts the parser in the state that expects the
//   header tag, as if the next byte were marked as the start of a new file.
`default_nettype none
module midi_file_stream_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_new_file,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [3:0]  rsp_role,
   output      logic [15:0] rsp_track_index,
   output      logic [7:0]  rsp_meta_type,
   output      logic        rsp_text_last,
   output      logic [7:0]  rsp_status_byte,
   output      logic [2:0]  rsp_error_code,
   output      logic [1:0]  rsp_warning,
   output      logic        rsp_length_mismatch,
   output      logic signed [31:0] rsp_length_difference,
   output      logic        rsp_done_res
);
   import mfsp_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_new_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   result_type core_res;
   logic       step;

   assign step = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || step;

   always_comb begin
      in_vld_in = req_ready ? req_valid : in_vld_ff;
      out_vld_in = step || (out_vld_ff && !rsp_ready);
   end

   mfsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .new_file  (in_new_ff),
      .result    (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_new_ff <= req_new_file;
      end
      if (step) begin
         out_ff <= core_res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_role = out_ff.role;
   assign rsp_track_index = out_ff.track_index;
   assign rsp_meta_type = out_ff.meta_type;
   assign rsp_text_last = out_ff.text_last;
   assign rsp_status_byte = out_ff.status_byte;
   assign rsp_error_code = out_ff.error_code;
   assign rsp_warning = out_ff.warning;
   assign rsp_length_mismatch = out_ff.length_mismatch;
   assign rsp_length_difference = $signed(out_ff.length_difference);
   assign rsp_done_res = out_ff.done_res;
endmodule
`default_nettype wire
